// ===== hdl/kvs_pkg.sv =====
// Shared types and constants for the key velocity scanner.
package kvs_pkg;

	localparam int CNT_W        = 16;
	localparam int KEYS_PER_ROW = 12;
	localparam int DEF_OCTAVES  = 7;
	localparam int JIDX_W       = $clog2(KEYS_PER_ROW);
	localparam int DIV_STEPS    = CNT_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'd65534;
	localparam logic [CNT_W-1:0] SOUNDING  = 16'd65535;
	localparam logic [6:0]       VEL_MAX   = 7'd127;

	localparam logic [KEYS_PER_ROW-1:0] MASK_LOW_EDGE  = 12'b111111111000;
	localparam logic [KEYS_PER_ROW-1:0] MASK_HIGH_EDGE = 12'b000001111111;
	localparam logic [KEYS_PER_ROW-1:0] MASK_ALL       = 12'b111111111111;

	localparam logic [5:0]       RST_BASE_NOTE      = 6'd24;
	localparam logic [CNT_W-1:0] RST_VELOCITY_SCALE = 16'd1400;
	localparam logic             RST_UPPER_IDLE     = 1'b1;

	localparam int PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_BASE_NOTE      = 2'd0,
		REG_VELOCITY_SCALE = 2'd1,
		REG_UPPER_IDLE     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/key_velocity_scanner_top.sv =====
// Key velocity scanner: per-key contact timers with note-on/off events.
// An item with an octave out of range is taken while idle and does nothing.
// Otherwise an item makes a flag pass and an update pass over its 12 keys in the counter
// memory. Each event adds an emit state, after the 16-step divider for a note-on with a
// non-zero count; emit waits on a stalled output. One item is in work at a time.
// Reset sets register defaults, clears the per-key valid bits: all counters read zero.
module key_velocity_scanner_top
	import kvs_pkg::*;
#(
	parameter int OCTAVES = DEF_OCTAVES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [2:0]         octave,
	input  logic               upper_row,
	input  logic [11:0]        contacts,
	output logic               event_valid,
	input  logic               event_ready,
	output logic               note_on,
	output logic [6:0]         note,
	output logic [6:0]         velocity,
	output logic               last_event
);

	localparam int KEYS = OCTAVES * KEYS_PER_ROW;
	localparam int KW   = $clog2(KEYS);

	// Configuration registers
	logic [5:0]       base_note_q;
	logic [CNT_W-1:0] velocity_scale_q;
	logic             upper_idle_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_note_q      <= RST_BASE_NOTE;
			velocity_scale_q <= RST_VELOCITY_SCALE;
			upper_idle_q     <= RST_UPPER_IDLE;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_BASE_NOTE:      base_note_q      <= pwdata[5:0];
				REG_VELOCITY_SCALE: velocity_scale_q <= pwdata[CNT_W-1:0];
				REG_UPPER_IDLE:     upper_idle_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_BASE_NOTE:      prdata = {26'd0, base_note_q};
			REG_VELOCITY_SCALE: prdata = {16'd0, velocity_scale_q};
			REG_UPPER_IDLE:     prdata = {31'd0, upper_idle_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Sequencer state and item registers
	state_t                  state_q, state_d;
	logic [KEYS_PER_ROW-1:0] row_q;
	logic                    upper_q;
	logic [KW-1:0]           start_q;
	logic [JIDX_W-1:0]       j_q;
	logic [KEYS_PER_ROW-1:0] flags_q;

	// Counter memory with per-key valid bits
	logic [CNT_W-1:0] mem [KEYS];
	logic [KEYS-1:0]  vld_q;
	logic [CNT_W-1:0] mem_rd_q;
	logic             rd_vld_q;

	// Event and divider registers
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] div_rem_q;
	logic [CNT_W-1:0] div_quo_q;
	logic [3:0]       div_step_q;
	logic             ev_on_q;
	logic [6:0]       ev_note_q;
	logic [6:0]       ev_vel_q;
	logic             ev_last_q;

	// Output register
	logic       out_valid_q;
	logic       out_on_q;
	logic [6:0] out_note_q;
	logic [6:0] out_vel_q;
	logic       out_last_q;

	// Combinational helpers
	logic                    in_range;
	logic [KEYS_PER_ROW-1:0] row_in;
	logic [7:0]              start_full;
	logic [KW-1:0]           key_addr;
	logic [CNT_W-1:0]        cnt_eff;
	logic                    closed;
	logic                    last_key;
	logic                    ev;
	logic [CNT_W-1:0]        cnt_new;
	logic                    need_div;
	logic [KEYS_PER_ROW-1:0] flags_rest;
	logic [CNT_W:0]          rem_sh;
	logic                    div_ge;
	logic [CNT_W-1:0]        rem_next;
	logic [CNT_W-1:0]        quo_next;
	logic                    out_free;

	// Control outputs of the sequencer
	logic accept, rd_en, wr_en, load_out, div_run;

	assign in_range   = {1'b0, octave} < 4'(OCTAVES);
	assign start_full = ({5'd0, octave} << 3) + ({5'd0, octave} << 2);
	assign key_addr   = start_q + KW'(j_q);
	assign cnt_eff    = rd_vld_q ? mem_rd_q : '0;
	assign closed     = row_q[j_q];
	assign last_key   = (j_q == JIDX_W'(KEYS_PER_ROW - 1));
	assign out_free   = !out_valid_q || event_ready;
	assign flags_rest = flags_q & ~(KEYS_PER_ROW'(1) << j_q);
	assign need_div   = !upper_q && (cnt_eff != '0);

	always_comb begin
		row_in = contacts;
		if (upper_row) begin
			if (upper_idle_q)
				row_in = ~contacts & MASK_ALL;
			if (octave == 3'd0)
				row_in = row_in & MASK_LOW_EDGE;
			if ({1'b0, octave} == 4'(OCTAVES - 1))
				row_in = row_in & MASK_HIGH_EDGE;
		end
	end

	// Key decision: the same test serves the flag pass and the update pass.
	always_comb begin
		ev      = 1'b0;
		cnt_new = cnt_eff;
		if (upper_q) begin
			if (closed) begin
				if (cnt_eff < COUNT_MAX)
					cnt_new = cnt_eff + 1'b1;
			end else begin
				ev      = (cnt_eff == SOUNDING);
				cnt_new = '0;
			end
		end else if (closed && cnt_eff != SOUNDING) begin
			ev      = 1'b1;
			cnt_new = SOUNDING;
		end
	end

	// One restoring division step per cycle.
	always_comb begin
		rem_sh   = {div_rem_q, div_quo_q[CNT_W-1]};
		div_ge   = rem_sh >= {1'b0, cnt_q};
		rem_next = div_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];
		quo_next = {div_quo_q[CNT_W-2:0], div_ge};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (item_valid && in_range)
					state_d = ST_SCAN_RD;
			ST_SCAN_RD:
				state_d = ST_SCAN_EV;
			ST_SCAN_EV:
				state_d = last_key ? ST_WALK_RD : ST_SCAN_RD;
			ST_WALK_RD:
				state_d = ST_WALK_EV;
			ST_WALK_EV:
				if (ev)
					state_d = need_div ? ST_DIV : ST_EMIT;
				else
					state_d = last_key ? ST_IDLE : ST_WALK_RD;
			ST_DIV:
				if (div_step_q == 4'(DIV_STEPS - 1))
					state_d = ST_EMIT;
			ST_EMIT:
				if (out_free)
					state_d = last_key ? ST_IDLE : ST_WALK_RD;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item_ready = 1'b0;
		accept     = 1'b0;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		load_out   = 1'b0;
		div_run    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				accept     = item_valid && in_range;
			end
			ST_SCAN_RD, ST_WALK_RD:
				rd_en = 1'b1;
			ST_WALK_EV:
				wr_en = upper_q || ev;
			ST_DIV:
				div_run = 1'b1;
			ST_EMIT:
				load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Item registers and key position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			flags_q <= '0;
		end else begin
			if (accept) begin
				j_q     <= '0;
				flags_q <= '0;
			end
			if (state_q == ST_SCAN_EV) begin
				flags_q[j_q] <= ev;
				j_q          <= last_key ? '0 : j_q + 1'b1;
			end
			if (state_q == ST_WALK_EV) begin
				flags_q[j_q] <= 1'b0;
				if (!ev && !last_key)
					j_q <= j_q + 1'b1;
			end
			if (load_out && !last_key)
				j_q <= j_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q   <= row_in;
			upper_q <= upper_row;
			start_q <= KW'(start_full);
		end
	end

	// Counter memory
	always_ff @(posedge clk) begin
		if (rd_en)
			mem_rd_q <= mem[key_addr];
		if (wr_en)
			mem[key_addr] <= cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_vld_q <= vld_q[key_addr];
			if (wr_en)
				vld_q[key_addr] <= 1'b1;
		end
	end

	// Event capture and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_step_q <= '0;
		else if (state_q == ST_WALK_EV)
			div_step_q <= '0;
		else if (div_run)
			div_step_q <= div_step_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK_EV && ev) begin
			ev_on_q   <= !upper_q;
			ev_note_q <= 7'(8'(key_addr) + {2'd0, base_note_q});
			ev_last_q <= (flags_rest == '0);
			ev_vel_q  <= upper_q ? 7'd0 : VEL_MAX;
			cnt_q     <= cnt_eff;
			div_rem_q <= '0;
			div_quo_q <= velocity_scale_q;
		end
		if (div_run) begin
			div_rem_q <= rem_next;
			div_quo_q <= quo_next;
			if (div_step_q == 4'(DIV_STEPS - 1))
				ev_vel_q <= (quo_next > CNT_W'(VEL_MAX)) ? VEL_MAX : quo_next[6:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (event_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_on_q   <= ev_on_q;
			out_note_q <= ev_note_q;
			out_vel_q  <= ev_vel_q;
			out_last_q <= ev_last_q;
		end
	end

	assign event_valid = out_valid_q;
	assign note_on     = out_on_q;
	assign note        = out_note_q;
	assign velocity    = out_vel_q;
	assign last_event  = out_last_q;

	// A note-off always carries zero velocity.
	a_off_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !note_on |-> velocity == 7'd0)
		else $error("note-off with non-zero velocity");

	// An item in range keeps the block busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && in_range |=> !item_ready)
		else $error("ready again directly after an item in range");

	// The divider only runs on a note-on with a non-zero count.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> ev_on_q && cnt_q != '0)
		else $error("divider running without a valid divisor");

	// A stalled event is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !event_valid || event_ready)
		else $error("event register loaded while an event waits");

endmodule
